@@ design/fbc_pkg.sv @@
// ---------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants for the frustum box culling unit: field widths,
// arithmetic widths of the plane test, register indexes and payload structs.
// ---------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

    // Coordinate width of the box corners.
    localparam int COORD_BITS  = 16;
    localparam int TAG_W       = 16;
    localparam int NUM_PLANES  = 6;
    localparam int NORMAL_FRAC = 14;
    localparam int NORM_W      = 16;
    localparam int PLANE_W     = 64;

    // Doubled center and doubled extent need one extra bit.
    localparam int SUM_W    = COORD_BITS + 1;
    // Magnitude of a normal component, kept signed for the multiply.
    localparam int MAG_W    = NORM_W + 1;
    localparam int DIST_P_W = NORM_W + SUM_W;
    localparam int RAD_P_W  = MAG_W + SUM_W;
    // Plane offset scaled into units of 2^-15.
    localparam int DOFF_W   = NORM_W + NORMAL_FRAC + 1;
    // Three products plus the offset: two guard bits over the widest term.
    localparam int ACC_W    = ((RAD_P_W > DOFF_W) ? RAD_P_W : DOFF_W) + 2;

    // Configuration port.
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    // Register indexes of the plane registers.
    localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOP    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NEAR   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FAR    = 3'd5;

    // One box request.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] box_min_x;
        logic signed [COORD_BITS-1:0] box_min_y;
        logic signed [COORD_BITS-1:0] box_min_z;
        logic signed [COORD_BITS-1:0] box_max_x;
        logic signed [COORD_BITS-1:0] box_max_y;
        logic signed [COORD_BITS-1:0] box_max_z;
        logic        [TAG_W-1:0]      object_tag;
    } t_box_req;

    // One culling result.
    typedef struct packed {
        logic             visible;
        logic [TAG_W-1:0] result_tag;
    } t_cull_result;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_stage_ld;

endpackage

`default_nettype wire

@@ design/frustum_box_culling_unit.sv @@
// Pipeline: four register stages (box prep, products, sums, output) that an
// accepted box request moves through in order, as the output side allows.
// Throughput: one box per cycle while the result side does not stall, set by the
// fully pipelined plane testers (six in parallel, one multiplier per product).
// Reset: synchronous, active low; clears the valid bits and sets all six plane
// registers to zero, so every box reads as not visible until planes are written.
// ---------------------------------------------------------------------------
// frustum_box_culling_unit
// Axis-aligned box versus six-plane frustum culling, one box per cycle unless
// the result side stalls, with an APB-style port holding the plane registers.
// ---------------------------------------------------------------------------
`default_nettype none

module frustum_box_culling_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Box request channel.
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  fbc_pkg::t_box_req                    i_box_req,
    // Result channel.
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output fbc_pkg::t_cull_result                o_result,
    // Configuration port.
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [fbc_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire  [fbc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [fbc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import fbc_pkg::*;

    logic [PLANE_W-1:0]    r_plane [NUM_PLANES];
    logic [REG_IDX_W-1:0]  w_idx;
    logic                  w_wr;
    t_stage_ld             w_ld;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic                  r_v4;
    logic [TAG_W-1:0]      r_tag1;
    logic [TAG_W-1:0]      r_tag2;
    logic [TAG_W-1:0]      r_tag3;
    t_cull_result          r_out;
    logic signed [SUM_W-1:0] w_c2 [3];
    logic signed [SUM_W-1:0] w_e2 [3];
    logic [NUM_PLANES-1:0] w_pass;

    // Register file: eight-byte registers, writes beyond the list are dropped.
    assign w_idx  = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_plane[i] <= '0;
            end
        end else if (w_wr && (w_idx <= REG_FAR)) begin
            r_plane[w_idx] <= pwdata;
        end
    end

    // Read data of the addressed register.
    always_comb begin
        prdata = '0;
        if (w_idx <= REG_FAR) begin
            prdata = r_plane[w_idx];
        end
    end

    // A stage loads when it is empty or its content moves on.
    assign w_ld.ld4 = !r_v4 || !i_stall;
    assign w_ld.ld3 = !r_v3 || w_ld.ld4;
    assign w_ld.ld2 = !r_v2 || w_ld.ld3;
    assign w_ld.ld1 = !r_v1 || w_ld.ld2;
    assign o_stall  = !w_ld.ld1;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_ld.ld1) begin
                r_v1 <= i_valid;
            end
            if (w_ld.ld2) begin
                r_v2 <= r_v1;
            end
            if (w_ld.ld3) begin
                r_v3 <= r_v2;
            end
            if (w_ld.ld4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Tag pipeline alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (w_ld.ld1) begin
            r_tag1 <= i_box_req.object_tag;
        end
        if (w_ld.ld2) begin
            r_tag2 <= r_tag1;
        end
        if (w_ld.ld3) begin
            r_tag3 <= r_tag2;
        end
    end

    // Doubled center and extent.
    fbc_box_prep u_box_prep (
        .i_clk     (i_clk),
        .i_box_req (i_box_req),
        .i_ld      (w_ld),
        .o_c2      (w_c2),
        .o_e2      (w_e2)
    );

    // One tester per plane, all in parallel.
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fbc_plane_test u_plane_test (
            .i_clk   (i_clk),
            .i_plane (r_plane[p]),
            .i_c2    (w_c2),
            .i_e2    (w_e2),
            .i_ld    (w_ld),
            .o_pass  (w_pass[p])
        );
    end

    // Output register: visible only if inside or crossing every plane.
    always_ff @(posedge i_clk) begin
        if (w_ld.ld4) begin
            r_out.visible    <= &w_pass;
            r_out.result_tag <= r_tag3;
        end
    end

    assign o_valid  = r_v4;
    assign o_result = r_out;

endmodule

`default_nettype wire

@@ design/fbc_box_prep.sv @@
// ---------------------------------------------------------------------------
// fbc_box_prep
// First pipeline stage: forms the doubled center (min + max) and the doubled
// extent (max - min) of the box on each axis.
// ---------------------------------------------------------------------------
`default_nettype none

module fbc_box_prep (
    input  wire                               i_clk,
    input  fbc_pkg::t_box_req                 i_box_req,
    input  fbc_pkg::t_stage_ld                i_ld,
    output logic signed [fbc_pkg::SUM_W-1:0]  o_c2 [3],
    output logic signed [fbc_pkg::SUM_W-1:0]  o_e2 [3]
);
    import fbc_pkg::*;

    logic signed [COORD_BITS-1:0] w_lo [3];
    logic signed [COORD_BITS-1:0] w_hi [3];
    logic signed [SUM_W-1:0]      r_c2 [3];
    logic signed [SUM_W-1:0]      r_e2 [3];
    logic signed [SUM_W-1:0]      n_c2 [3];
    logic signed [SUM_W-1:0]      n_e2 [3];

    assign w_lo[0] = i_box_req.box_min_x;
    assign w_lo[1] = i_box_req.box_min_y;
    assign w_lo[2] = i_box_req.box_min_z;
    assign w_hi[0] = i_box_req.box_max_x;
    assign w_hi[1] = i_box_req.box_max_y;
    assign w_hi[2] = i_box_req.box_max_z;

    // Sign-extended sum and difference per axis; an inverted box keeps its
    // negative extent.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c2[k] = SUM_W'(w_lo[k]) + SUM_W'(w_hi[k]);
            n_e2[k] = SUM_W'(w_hi[k]) - SUM_W'(w_lo[k]);
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_c2 <= n_c2;
            r_e2 <= n_e2;
        end
    end

    assign o_c2 = r_c2;
    assign o_e2 = r_e2;

endmodule

`default_nettype wire

@@ design/fbc_plane_test.sv @@
// ---------------------------------------------------------------------------
// fbc_plane_test
// Test of the box against one plane: products in the second stage, sums in
// the third, and the compare dist < radius feeding the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module fbc_plane_test (
    input  wire                               i_clk,
    input  wire  [fbc_pkg::PLANE_W-1:0]       i_plane,
    input  logic signed [fbc_pkg::SUM_W-1:0]  i_c2 [3],
    input  logic signed [fbc_pkg::SUM_W-1:0]  i_e2 [3],
    input  fbc_pkg::t_stage_ld                i_ld,
    output logic                              o_pass
);
    import fbc_pkg::*;

    logic signed [NORM_W-1:0]   w_nrm [3];
    logic signed [MAG_W-1:0]    w_nx  [3];
    logic signed [MAG_W-1:0]    w_mag [3];
    logic signed [NORM_W-1:0]   w_d;
    logic signed [DIST_P_W-1:0] n_dist_p [3];
    logic signed [RAD_P_W-1:0]  n_rad_p  [3];
    logic signed [ACC_W-1:0]    n_d_term;
    logic signed [DIST_P_W-1:0] r_dist_p [3];
    logic signed [RAD_P_W-1:0]  r_rad_p  [3];
    logic signed [ACC_W-1:0]    r_d_term;
    logic signed [ACC_W-1:0]    n_dist;
    logic signed [ACC_W-1:0]    n_rad;
    logic signed [ACC_W-1:0]    r_dist;
    logic signed [ACC_W-1:0]    r_rad;

    // Unpack the normal components and the offset.
    assign w_nrm[0] = i_plane[NORM_W-1:0];
    assign w_nrm[1] = i_plane[2*NORM_W-1:NORM_W];
    assign w_nrm[2] = i_plane[3*NORM_W-1:2*NORM_W];
    assign w_d      = i_plane[4*NORM_W-1:3*NORM_W];

    // Per-axis products: normal times centre, magnitude times extent.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_nx[k]     = MAG_W'(w_nrm[k]);
            w_mag[k]    = w_nx[k][MAG_W-1] ? -w_nx[k] : w_nx[k];
            n_dist_p[k] = w_nrm[k] * i_c2[k];
            n_rad_p[k]  = w_mag[k] * i_e2[k];
        end
        n_d_term = ACC_W'(w_d) <<< (NORMAL_FRAC + 1);
    end

    // Second stage register.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld2) begin
            r_dist_p <= n_dist_p;
            r_rad_p  <= n_rad_p;
            r_d_term <= n_d_term;
        end
    end

    // Sums of the signed distance and of the projected radius.
    always_comb begin
        n_dist = ACC_W'(r_dist_p[0]) + ACC_W'(r_dist_p[1]) + ACC_W'(r_dist_p[2]) + r_d_term;
        n_rad  = ACC_W'(r_rad_p[0]) + ACC_W'(r_rad_p[1]) + ACC_W'(r_rad_p[2]);
    end

    // Third stage register.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld3) begin
            r_dist <= n_dist;
            r_rad  <= n_rad;
        end
    end

    // The box is not outside this plane when the distance is below the radius.
    assign o_pass = (r_dist < r_rad);

endmodule

`default_nettype wire

@@ design/fbc_checker.sv @@
// ---------------------------------------------------------------------------
// fbc_checker
// Port-level checks of the culling unit: reset, back-pressure, pipeline
// latency and output hold under stall. Bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module fbc_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_valid,
    input wire                    o_stall,
    input wire                    o_valid,
    input wire                    i_stall,
    input fbc_pkg::t_cull_result  o_result
);
    import fbc_pkg::*;

    // Reset empties the pipeline and lifts back-pressure.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("pipeline not empty after reset");

    // Back-pressure only comes from a waiting, stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // An accepted box reaches the output if the result side does not stall meanwhile.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("result missing after pipeline latency");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed");

endmodule

bind frustum_box_culling_unit fbc_checker u_fbc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_result  (o_result)
);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the frustum box culling unit. Boxes are streamed in
// bursts against a stalling result side, and each verdict is compared with an
// integer prediction made from a local copy of the six plane registers.
// ---------------------------------------------------------------------------

module testbench;

    import fbc_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int LONG_HOLD       = 80;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int RANDOM_PHASES   = 8;
    // 1.0 in Q1.14.
    localparam int UNIT_NORMAL     = 16384;

    // Register indexes past the last plane; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // Block ports; the inputs driven by the bench are known from time zero.
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic                  o_stall;
    t_box_req              i_box_req = '0;
    logic                  o_valid;
    logic                  i_stall   = 1'b0;
    t_cull_result          o_result;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Bench state.
    t_box_req         pending_boxes[$];
    t_cull_result     expected_verdicts[$];
    t_cull_result     oldest_verdict;
    logic [PLANE_W-1:0] plane_copy [NUM_PLANES] = '{default: '0};
    int               error_count  = 0;
    int               results_seen = 0;
    int               burst_left   = 0;
    int               gap_left     = 0;
    int               hold_left    = 0;
    int               next_hold_at = 40;
    int               mode_left    = 0;
    int               stall_mode   = 0;

    frustum_box_culling_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_box_req (i_box_req),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Expected verdict for one box under the current plane registers. Doubled
    // center and extent keep everything in units of 2^-15, so D is scaled by
    // 2^15. A plane rejects the box when its distance is not below the radius.
    function automatic t_cull_result cull_verdict(t_box_req box);
        logic signed [COORD_BITS-1:0] lo [3];
        logic signed [COORD_BITS-1:0] hi [3];
        longint centre2 [3];
        longint extent2 [3];
        longint plane_dist;
        longint radius;
        longint n;
        t_cull_result res;
        lo[0] = box.box_min_x;
        lo[1] = box.box_min_y;
        lo[2] = box.box_min_z;
        hi[0] = box.box_max_x;
        hi[1] = box.box_max_y;
        hi[2] = box.box_max_z;
        for (int k = 0; k < 3; k++) begin
            centre2[k] = longint'(lo[k]) + longint'(hi[k]);
            extent2[k] = longint'(hi[k]) - longint'(lo[k]);
        end
        res.visible    = 1'b1;
        res.result_tag = box.object_tag;
        for (int p = 0; p < NUM_PLANES; p++) begin
            plane_dist = longint'($signed(plane_copy[p][PLANE_W-1 -: NORM_W]))
                         * (longint'(1) << (NORMAL_FRAC + 1));
            radius = 0;
            for (int k = 0; k < 3; k++) begin
                n = longint'($signed(plane_copy[p][NORM_W*k +: NORM_W]));
                plane_dist += n * centre2[k];
                radius     += (n < 0 ? -n : n) * extent2[k];
            end
            if (plane_dist >= radius) begin
                res.visible = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic t_box_req make_box(int mnx, int mny, int mnz,
                                          int mxx, int mxy, int mxz, int tag);
        t_box_req box;
        box.box_min_x  = COORD_BITS'(mnx);
        box.box_min_y  = COORD_BITS'(mny);
        box.box_min_z  = COORD_BITS'(mnz);
        box.box_max_x  = COORD_BITS'(mxx);
        box.box_max_y  = COORD_BITS'(mxy);
        box.box_max_z  = COORD_BITS'(mxz);
        box.object_tag = TAG_W'(tag);
        return box;
    endfunction

    function automatic int clip_coord(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int jitter(int amount);
        return int'($urandom_range(0, 2 * amount)) - amount;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // Mostly well-formed boxes around the scene, plus raw bit patterns,
    // inverted boxes and corners at the coordinate extremes.
    function automatic t_box_req random_box(int span);
        int lo [3];
        int hi [3];
        int centre;
        int half;
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            centre = int'($urandom_range(0, 2 * span)) - span;
            half   = $urandom_range(0, span / 2);
            lo[k]  = clip_coord(centre - half);
            hi[k]  = clip_coord(centre + half);
            if (kind == 6 || kind == 7) begin
                lo[k] = int'($urandom);
                hi[k] = int'($urandom);
            end else if (kind == 8) begin
                centre = lo[k];
                lo[k]  = hi[k];
                hi[k]  = centre;
            end else if (kind == 9) begin
                lo[k] = pick_extreme();
                hi[k] = pick_extreme();
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], int'($urandom));
    endfunction

    function automatic logic [PLANE_W-1:0] plane_word(int a, int b, int c, int d);
        return {NORM_W'(d), NORM_W'(c), NORM_W'(b), NORM_W'(a)};
    endfunction

    // Plane facing +axis (dir 1) or -axis (dir -1) through the given edge,
    // with optional noise on the normal.
    function automatic logic [PLANE_W-1:0] axis_plane(int axis, int dir, int edge_pos,
                                                      int noise);
        int comp [3];
        for (int k = 0; k < 3; k++) begin
            comp[k] = (k == axis) ? dir * (UNIT_NORMAL + jitter(noise)) : jitter(noise / 4);
        end
        return plane_word(comp[0], comp[1], comp[2], -dir * edge_pos);
    endfunction

    // Register write with a setup and an access phase; mapped registers are
    // read back right after.
    task automatic write_plane(logic [REG_IDX_W-1:0] idx, logic [PLANE_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx < NUM_PLANES) begin
            plane_copy[idx] = value;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata !== value) begin
                flag_mismatch($sformatf("register %0d reads %h, wrote %h",
                                        idx, prdata, value));
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure_frustum(int cx, int cy, int cz, int wx, int wy, int wz,
                                     int noise);
        write_plane(REG_RIGHT,  axis_plane(0,  1, cx + wx, noise));
        write_plane(REG_LEFT,   axis_plane(0, -1, cx - wx, noise));
        write_plane(REG_TOP,    axis_plane(1,  1, cy + wy, noise));
        write_plane(REG_BOTTOM, axis_plane(1, -1, cy - wy, noise));
        write_plane(REG_NEAR,   axis_plane(2, -1, cz - wz, noise));
        write_plane(REG_FAR,    axis_plane(2,  1, cz + wz, noise));
    endtask

    // Waits until every queued request is taken and answered, then lets the
    // pipeline settle.
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(posedge i_clk);
        while ((pending_boxes.size() != 0 || i_valid || expected_verdicts.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // A request taken at this edge gets its verdict predicted now.
            if (i_valid && !o_stall) begin
                expected_verdicts.push_back(cull_verdict(i_box_req));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_boxes.size() > 0) begin
                    i_box_req <= pending_boxes.pop_front();
                    i_valid   <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall pattern: changing modes, with a long hold-off now and then
    // so that the pipeline fills and the request side stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_left == 0 && results_seen >= next_hold_at) begin
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + 450;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(8, 60);
                end
                mode_left--;
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 9) < 6);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // Result monitor: each accepted verdict against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (expected_verdicts.size() == 0) begin
                flag_mismatch($sformatf("unexpected result, tag %h", o_result.result_tag));
            end else begin
                oldest_verdict = expected_verdicts.pop_front();
                if (o_result.visible !== oldest_verdict.visible) begin
                    flag_mismatch($sformatf("tag %h: visible %b, predicted %b",
                                            oldest_verdict.result_tag,
                                            o_result.visible, oldest_verdict.visible));
                end
                if (o_result.result_tag !== oldest_verdict.result_tag) begin
                    flag_mismatch($sformatf("result tag %h, predicted %h",
                                            o_result.result_tag,
                                            oldest_verdict.result_tag));
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int span;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Planes still zero after reset: nothing can be visible.
        pending_boxes.push_back(make_box(-10, -10, -10, 10, 10, 10, 16'h0000));
        pending_boxes.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767,
                                         16'hFFFF));
        pending_boxes.push_back(make_box(0, 0, 0, 0, 0, 0, 16'h1234));
        pending_boxes.push_back(make_box(10, 10, 10, -10, -10, -10, 16'h8001));
        wait_idle();

        // Cube frustum of half-size 1000 around the origin, with unit normals.
        configure_frustum(0, 0, 0, 1000, 1000, 1000, 0);
        pending_boxes.push_back(make_box(-50, -50, -50, 50, 50, 50, 16'hFFFF));
        pending_boxes.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767,
                                         16'h0000));
        pending_boxes.push_back(make_box(1500, 0, 0, 2000, 10, 10, 16'h0001));
        pending_boxes.push_back(make_box(-2000, 0, 0, -1500, 10, 10, 16'h0002));
        pending_boxes.push_back(make_box(0, 1500, 0, 10, 2000, 10, 16'h0003));
        pending_boxes.push_back(make_box(0, -2000, 0, 10, -1500, 10, 16'h0004));
        pending_boxes.push_back(make_box(0, 0, 1500, 10, 10, 2000, 16'h0005));
        pending_boxes.push_back(make_box(0, 0, -2000, 10, 10, -1500, 16'h0006));
        // Straddling a face, then points exactly on and just inside it.
        pending_boxes.push_back(make_box(900, -5, -5, 1100, 5, 5, 16'h0007));
        pending_boxes.push_back(make_box(1000, 0, 0, 1000, 0, 0, 16'h0008));
        pending_boxes.push_back(make_box(999, 0, 0, 999, 0, 0, 16'h0009));
        // Inverted boxes: negative extent used as is; then points at the extremes.
        pending_boxes.push_back(make_box(10, 10, 10, -10, -10, -10, 16'h000A));
        pending_boxes.push_back(make_box(1100, 10, 10, 900, -10, -10, 16'h000B));
        pending_boxes.push_back(make_box(-32768, -32768, -32768, -32768, -32768, -32768,
                                         16'h7FFF));
        pending_boxes.push_back(make_box(32767, 32767, 32767, 32767, 32767, 32767,
                                         16'h8000));
        wait_idle();

        // Writes past the last plane change nothing.
        write_plane(REG_UNMAPPED_LO, '1);
        write_plane(REG_UNMAPPED_HI, '1);
        pending_boxes.push_back(make_box(-50, -50, -50, 50, 50, 50, 16'hA5A5));
        pending_boxes.push_back(make_box(1500, 0, 0, 2000, 10, 10, 16'h5A5A));
        wait_idle();

        // Random phases under extreme, random and frustum-shaped planes.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: for (int i = 0; i < NUM_PLANES; i++)
                       write_plane(REG_IDX_W'(i), 64'h8000_8000_8000_8000);
                1: for (int i = 0; i < NUM_PLANES; i++)
                       write_plane(REG_IDX_W'(i), 64'h7FFF_7FFF_7FFF_7FFF);
                2: for (int i = 0; i < NUM_PLANES; i++)
                       write_plane(REG_IDX_W'(i), (i % 2 == 1) ? 64'h7FFF_8000_8000_8000
                                                               : 64'h8000_7FFF_7FFF_7FFF);
                3: for (int i = 0; i < NUM_PLANES; i++)
                       write_plane(REG_IDX_W'(i), {$urandom, $urandom});
                default: configure_frustum(jitter(5000), jitter(5000), jitter(5000),
                                           $urandom_range(1, 20000),
                                           $urandom_range(1, 20000),
                                           $urandom_range(1, 20000), 512);
            endcase
            span = (p < 4) ? 32767 : $urandom_range(200, 30000);
            repeat (ITEMS_PER_PHASE) pending_boxes.push_back(random_box(span));
            wait_idle();
        end

        if (expected_verdicts.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ frustum_box_culling_unit.f @@
design/fbc_pkg.sv
design/fbc_box_prep.sv
design/fbc_plane_test.sv
design/frustum_box_culling_unit.sv
design/fbc_checker.sv
bench/testbench.sv
